[rtl/wb3_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the weighted 3x3 blur.
// No dependencies.
package wb3_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam int CENTER_MUL = 5;
  localparam int AMT_BASE   = 11;
  localparam int AMT_MAX    = 10;
  localparam int CHAN_MAX   = 255;

  // Weighted sum is at most 255 * 58, divisor at most 58.
  localparam int NUM_W = 14;
  localparam int DEN_W = 6;

  localparam logic [1:0] REG_AMOUNT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef logic [NUM_W-1:0] num_t;

endpackage

[rtl/wb3_div.sv]
`timescale 1ns / 1ps
// Three-lane restoring divider, one quotient bit per cycle per lane.
// Depends on wb3_pkg.
module wb3_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  wb3_pkg::num_t               numer [3],
  input  logic [wb3_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output wb3_pkg::num_t               quot [3]
);

  localparam int CNT_W = $clog2(wb3_pkg::NUM_W + 1);

  wb3_pkg::num_t             q      [3];
  wb3_pkg::num_t             q_next [3];
  logic [wb3_pkg::DEN_W-1:0] r      [3];
  logic [wb3_pkg::DEN_W-1:0] r_next [3];
  logic [wb3_pkg::DEN_W-1:0] d;
  logic [CNT_W-1:0]          cnt;

  always_comb begin
    logic [wb3_pkg::DEN_W:0] t;
    for (int c = 0; c < 3; c++) begin
      t = {r[c], q[c][wb3_pkg::NUM_W-1]};
      if (t >= {1'b0, d}) begin
        r_next[c] = wb3_pkg::DEN_W'(t - {1'b0, d});
        q_next[c] = {q[c][wb3_pkg::NUM_W-2:0], 1'b1};
      end else begin
        r_next[c] = wb3_pkg::DEN_W'(t);
        q_next[c] = {q[c][wb3_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(wb3_pkg::NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d <= den;
      for (int c = 0; c < 3; c++) begin
        q[c] <= numer[c];
        r[c] <= '0;
      end
    end else if (cnt != '0) begin
      for (int c = 0; c < 3; c++) begin
        q[c] <= q_next[c];
        r[c] <= r_next[c];
      end
    end
  end

  assign quot = q;

endmodule

[rtl/weighted_blur_3x3.sv]
`timescale 1ns / 1ps
// Weighted 3x3 blur over a raster RGB stream, two line memories and a 3x3 window.
// Depends on wb3_pkg and wb3_div.
//
//  channel | signals                                         | handshake
//  in      | in_red, in_green, in_blue                       | in_valid / in_ready
//  out     | out_red/green/blue, out_column, out_row, lasts  | out_valid / out_ready
//  cfg     | cfg_index, cfg_data                             | cfg_write, no wait
//
// A pixel is taken in the idle state, then the line memories are read and the window
// updated; per result follow a summing state, the divider (skipped when the amount is
// 0) and the output register; up to four results per pixel, one at a time.
// The divider gives one quotient bit per cycle.
// Reset is synchronous; the line memories are not cleared.
// A stalled result holds in the output register; no pixel is taken meanwhile.
module weighted_blur_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [10:0] out_column,
  output logic [15:0] out_row,
  output logic        run_last,
  output logic        frame_last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [13:0] MAXW = 14'(MAX_WIDTH);

  wb3_pkg::state_t state, state_next;

  logic [3:0]  blur_amount;
  logic [11:0] image_width;
  logic [15:0] image_height;

  logic [23:0] mem_upper [MAX_WIDTH];
  logic [23:0] mem_lower [MAX_WIDTH];
  logic [23:0] rd_upper, rd_lower;

  logic [23:0] win [3][3];
  logic [11:0] column_count;
  logic [15:0] row_count;

  logic [23:0] px;
  logic [11:0] x;
  logic [15:0] y;
  logic        eol, lastrow;
  logic [3:0]  mask;

  logic [13:0] weff;
  logic [15:0] heff;
  logic [11:0] xc;
  logic [15:0] yc;
  logic        eol_c, last_c;
  logic [3:0]  mask_new, job_hot, mask_rest;
  logic [1:0]  job;

  logic        accept_in, accept_out;
  logic [3:0]  amt;
  logic [5:0]  cw;
  logic        amt_zero;

  wb3_pkg::num_t quot  [3];
  wb3_pkg::num_t sum_c [3];
  logic [wb3_pkg::DEN_W-1:0] den_c;
  logic [23:0] centre;
  logic        div_start, div_done;

  // Frame geometry, clamped.
  always_comb begin
    weff = (image_width == '0) ? 14'd1 : {2'b0, image_width};
    if (weff > MAXW) begin
      weff = MAXW;
    end
    heff = (image_height == '0) ? 16'd1 : image_height;
    xc = ({2'b0, column_count} >= weff) ? 12'(weff - 14'd1) : column_count;
    yc = (row_count >= heff) ? heff - 16'd1 : row_count;
    eol_c  = ({2'b0, xc} == weff - 14'd1);
    last_c = (yc == heff - 16'd1);
  end

  assign accept_in  = in_valid && in_ready;
  assign accept_out = out_valid && out_ready;

  always_comb begin
    mask_new[0] = (y != '0) && (x != '0);
    mask_new[1] = (y != '0) && eol;
    mask_new[2] = lastrow && (x != '0);
    mask_new[3] = lastrow && eol;
  end

  // Lowest pending result goes first.
  always_comb begin
    job_hot   = mask & (~mask + 4'd1);
    mask_rest = mask & ~job_hot;
    case (job_hot)
      4'b0001: job = 2'd0;
      4'b0010: job = 2'd1;
      4'b0100: job = 2'd2;
      4'b1000: job = 2'd3;
      default: job = 2'd0;
    endcase
  end

  always_comb begin
    amt = (blur_amount > 4'(wb3_pkg::AMT_MAX)) ? 4'(wb3_pkg::AMT_MAX) : blur_amount;
    amt_zero = (amt == '0);
    cw = 6'(4'(wb3_pkg::AMT_BASE) - amt) * 6'(wb3_pkg::CENTER_MUL);
  end

  // Weighted window sum for the current result.
  always_comb begin
    int   rp, cp, wr, wc;
    logic lok, rok, uok, dok, use_px;
    logic [3:0] cnt;
    logic [10:0] ns [3];
    rp  = job[1] ? 2 : 1;
    cp  = job[0] ? 2 : 1;
    lok = job[0] ? (x >= 12'd1) : (x >= 12'd2);
    rok = !job[0];
    uok = job[1] ? (y >= 16'd1) : (y >= 16'd2);
    dok = !job[1];
    cnt = '0;
    for (int c = 0; c < 3; c++) begin
      ns[c] = '0;
    end
    centre = win[rp][cp];
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        wr = rp + dr - 1;
        wc = cp + dc - 1;
        use_px = !(dr == 1 && dc == 1) && !(dr == 0 && !uok) && !(dr == 2 && !dok)
                 && !(dc == 0 && !lok) && !(dc == 2 && !rok)
                 && wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2;
        if (use_px) begin
          cnt = cnt + 4'd1;
          ns[0] = ns[0] + 11'(win[wr][wc][23:16]);
          ns[1] = ns[1] + 11'(win[wr][wc][15:8]);
          ns[2] = ns[2] + 11'(win[wr][wc][7:0]);
        end
      end
    end
    sum_c[0] = wb3_pkg::NUM_W'(ns[0]) + wb3_pkg::NUM_W'(centre[23:16]) * wb3_pkg::NUM_W'(cw);
    sum_c[1] = wb3_pkg::NUM_W'(ns[1]) + wb3_pkg::NUM_W'(centre[15:8]) * wb3_pkg::NUM_W'(cw);
    sum_c[2] = wb3_pkg::NUM_W'(ns[2]) + wb3_pkg::NUM_W'(centre[7:0]) * wb3_pkg::NUM_W'(cw);
    den_c = cw + wb3_pkg::DEN_W'(cnt);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      wb3_pkg::ST_IDLE: if (in_valid) state_next = wb3_pkg::ST_READ;
      wb3_pkg::ST_READ: state_next = (mask_new != '0) ? wb3_pkg::ST_SUM : wb3_pkg::ST_IDLE;
      wb3_pkg::ST_SUM:  state_next = amt_zero ? wb3_pkg::ST_OUT : wb3_pkg::ST_DIV;
      wb3_pkg::ST_DIV:  if (div_done) state_next = wb3_pkg::ST_OUT;
      wb3_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next = (mask_rest != '0) ? wb3_pkg::ST_SUM : wb3_pkg::ST_IDLE;
        end
      end
      default: state_next = wb3_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    case (state)
      wb3_pkg::ST_IDLE: in_ready  = 1'b1;
      wb3_pkg::ST_SUM:  div_start = !amt_zero;
      wb3_pkg::ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wb3_pkg::ST_IDLE;
      blur_amount  <= '0;
      image_width  <= 12'd640;
      image_height <= 16'd480;
      column_count <= '0;
      row_count    <= '0;
      mask         <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          wb3_pkg::REG_AMOUNT: blur_amount  <= cfg_data[3:0];
          wb3_pkg::REG_WIDTH:  image_width  <= cfg_data[11:0];
          wb3_pkg::REG_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (accept_in) begin
        if (eol_c) begin
          column_count <= '0;
          row_count    <= last_c ? '0 : yc + 16'd1;
        end else begin
          column_count <= xc + 12'd1;
          row_count    <= yc;
        end
      end
      if (state == wb3_pkg::ST_READ) begin
        mask <= mask_new;
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= rd_upper;
        win[1][2] <= rd_lower;
        win[2][2] <= px;
      end
      if (accept_out) begin
        mask <= mask_rest;
      end
    end
  end

  // Pixel context captured at the request.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      px      <= {in_red, in_green, in_blue};
      x       <= xc;
      y       <= yc;
      eol     <= eol_c;
      lastrow <= last_c;
    end
  end

  // Line memories: read old value, write new one at the same column.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      rd_upper <= mem_upper[AW'(xc)];
      rd_lower <= mem_lower[AW'(xc)];
      mem_lower[AW'(xc)] <= {in_red, in_green, in_blue};
    end
    if (state == wb3_pkg::ST_READ) begin
      mem_upper[AW'(x)] <= rd_lower;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == wb3_pkg::ST_SUM) begin
      out_column <= 11'(job[0] ? x : x - 12'd1);
      out_row    <= job[1] ? y : y - 16'd1;
      run_last   <= (mask_rest == '0);
      frame_last <= (job == 2'd3);
      if (amt_zero) begin
        out_red   <= centre[23:16];
        out_green <= centre[15:8];
        out_blue  <= centre[7:0];
      end
    end
    if (state == wb3_pkg::ST_DIV && div_done) begin
      out_red   <= (quot[0] > wb3_pkg::NUM_W'(wb3_pkg::CHAN_MAX)) ? 8'hFF : quot[0][7:0];
      out_green <= (quot[1] > wb3_pkg::NUM_W'(wb3_pkg::CHAN_MAX)) ? 8'hFF : quot[1][7:0];
      out_blue  <= (quot[2] > wb3_pkg::NUM_W'(wb3_pkg::CHAN_MAX)) ? 8'hFF : quot[2][7:0];
    end
  end

  wb3_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (sum_c),
    .den   (den_c),
    .done  (div_done),
    .quot  (quot)
  );

endmodule

[dv/weighted_blur_3x3_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for weighted_blur_3x3: directed and random RGB frames under several blur settings.
// Depends on wb3_pkg and the blur RTL; expected pixels come from a built-in line/window model.
module weighted_blur_3x3_tb;

  localparam int LINE_DEPTH = 2048;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] column;
    logic [15:0] row;
    logic        run_end;
    logic        frame_end;
  } blurred_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = wb3_pkg::REG_AMOUNT;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red, out_green, out_blue;
  logic [10:0] out_column;
  logic [15:0] out_row;
  logic        run_last, frame_last;

  weighted_blur_3x3 dut (.*);

  always #4 clk = ~clk;

  // Blur model state
  int unsigned amount_reg = 0, width_reg = 640, height_reg = 480;
  logic [23:0] upper_line [LINE_DEPTH];
  logic [23:0] lower_line [LINE_DEPTH];
  logic [23:0] win [3][3];
  int unsigned col_cnt = 0, row_cnt = 0;

  pixel_t   pending_pixels[$];
  blurred_t expected_pixels[$];
  bit       failed = 0;
  bit       idling_on = 1;
  int       results_seen = 0;

  function automatic logic [23:0] blur_window(int rp, int cp, bit lok, bit rok,
                                               bit uok, bit dok);
    int unsigned amt, cw, sr, sg, sb, dv, wt, r, g, b;
    logic [23:0] px;
    amt = amount_reg > wb3_pkg::AMT_MAX ? wb3_pkg::AMT_MAX : amount_reg;
    if (amt == 0) return win[rp][cp];
    cw = wb3_pkg::CENTER_MUL * (wb3_pkg::AMT_BASE - amt);
    sr = 0; sg = 0; sb = 0; dv = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dr < 0 && !uok) || (dr > 0 && !dok) || (dc < 0 && !lok) || (dc > 0 && !rok))
          continue;
        if (rp + dr < 0 || rp + dr > 2 || cp + dc < 0 || cp + dc > 2) continue;
        wt = (dr == 0 && dc == 0) ? cw : 1;
        px = win[rp + dr][cp + dc];
        sr += px[23:16] * wt;
        sg += px[15:8] * wt;
        sb += px[7:0] * wt;
        dv += wt;
      end
    end
    r = sr / dv; g = sg / dv; b = sb / dv;
    if (r > wb3_pkg::CHAN_MAX) r = wb3_pkg::CHAN_MAX;
    if (g > wb3_pkg::CHAN_MAX) g = wb3_pkg::CHAN_MAX;
    if (b > wb3_pkg::CHAN_MAX) b = wb3_pkg::CHAN_MAX;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg == 0 ? 1 : width_reg;
    return w > LINE_DEPTH ? LINE_DEPTH : w;
  endfunction

  function automatic int unsigned eff_height();
    return height_reg == 0 ? 1 : height_reg;
  endfunction

  function automatic void blur_pixel(pixel_t p);
    int unsigned w, h, x, y;
    bit eol, lastrow;
    logic [23:0] up, lo, v;
    blurred_t res[$];
    blurred_t e;
    w = eff_width();
    h = eff_height();
    x = col_cnt >= w ? w - 1 : col_cnt;
    y = row_cnt >= h ? h - 1 : row_cnt;
    eol = (x == w - 1);
    lastrow = (y == h - 1);
    up = upper_line[x];
    lo = lower_line[x];
    upper_line[x] = lo;
    lower_line[x] = p;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = lo;
    win[2][2] = p;
    if (y >= 1) begin
      if (x >= 1) begin
        v = blur_window(1, 1, x >= 2, 1, y >= 2, 1);
        e = {v, 11'(x - 1), 16'(y - 1), 1'b0, 1'b0};
        res.push_back(e);
      end
      if (eol) begin
        v = blur_window(1, 2, x >= 1, 0, y >= 2, 1);
        e = {v, 11'(x), 16'(y - 1), 1'b0, 1'b0};
        res.push_back(e);
      end
    end
    if (lastrow) begin
      if (x >= 1) begin
        v = blur_window(2, 1, x >= 2, 1, y >= 1, 0);
        e = {v, 11'(x - 1), 16'(y), 1'b0, 1'b0};
        res.push_back(e);
      end
      if (eol) begin
        v = blur_window(2, 2, x >= 1, 0, y >= 1, 0);
        e = {v, 11'(x), 16'(y), 1'b0, 1'b1};
        res.push_back(e);
      end
    end
    if (res.size() > 0) res[res.size() - 1].run_end = 1'b1;
    foreach (res[i]) expected_pixels.push_back(res[i]);
    if (eol) begin
      col_cnt = 0;
      row_cnt = lastrow ? 0 : ((y + 1) & 16'hFFFF);
    end else begin
      col_cnt = x + 1;
      row_cnt = y;
    end
  endfunction

  // Source side: one request per pixel, random gap after each acceptance while idling is on
  int src_gap = 0;
  always @(posedge clk) begin
    pixel_t p;
    bit next_valid;
    if (rst) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        blur_pixel({in_red, in_green, in_blue});
        next_valid = 0;
        src_gap = idling_on ? $urandom_range(0, 3) : 0;
      end
      if (!next_valid) begin
        if (src_gap > 0) src_gap--;
        else if (pending_pixels.size() > 0) begin
          p = pending_pixels.pop_front();
          in_red <= p.red;
          in_green <= p.green;
          in_blue <= p.blue;
          next_valid = 1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Sink side: random stalls, plus one long hold-off to back up the pipeline
  int sink_wait = 0;
  int long_hold = 0;
  bit long_done = 0;
  always @(posedge clk) begin
    blurred_t got, exp;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_red, out_green, out_blue, out_column, out_row, run_last, frame_last};
        results_seen++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          failed = 1;
        end else begin
          exp = expected_pixels.pop_front();
          if (got.red !== exp.red || got.green !== exp.green || got.blue !== exp.blue)
            $display("%0t: rgb mismatch, expected %h%h%h actual %h%h%h", $time,
                     exp.red, exp.green, exp.blue, got.red, got.green, got.blue);
          if (got.column !== exp.column)
            $display("%0t: column mismatch, expected %0d actual %0d", $time,
                     exp.column, got.column);
          if (got.row !== exp.row)
            $display("%0t: row mismatch, expected %0d actual %0d", $time, exp.row, got.row);
          if (got.run_end !== exp.run_end)
            $display("%0t: run_last mismatch, expected %b actual %b", $time,
                     exp.run_end, got.run_end);
          if (got.frame_end !== exp.frame_end)
            $display("%0t: frame_last mismatch, expected %b actual %b", $time,
                     exp.frame_end, got.frame_end);
          if (got !== exp) failed = 1;
        end
        sink_wait = idling_on ? $urandom_range(0, 3) : 0;
        if (results_seen == 60 && !long_done) begin
          long_hold = 400;
          long_done = 1;
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      wb3_pkg::REG_AMOUNT: amount_reg = val & 16'hF;
      wb3_pkg::REG_WIDTH:  width_reg = val & 16'hFFF;
      wb3_pkg::REG_HEIGHT: height_reg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold until every pixel is taken and every result is back, then let the pipe drain
  task automatic wait_idle();
    do @(posedge clk) #1; while (pending_pixels.size() > 0 || in_valid ||
                                 expected_pixels.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mode 0: random, 1: all full scale, 2: all zero, 3: mixed extremes
  task automatic queue_pixels(int count, int mode);
    pixel_t p;
    for (int i = 0; i < count; i++) begin
      case (mode)
        1: p = '1;
        2: p = '0;
        3: p = {$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                $urandom_range(0, 1) ? 8'hFF : 8'h00};
        default: p = 24'($urandom);
      endcase
      pending_pixels.push_back(p);
    end
  endtask

  task automatic run_frame(int amt, int wid, int hgt, int mode);
    write_reg(wb3_pkg::REG_AMOUNT, 16'(amt));
    write_reg(wb3_pkg::REG_WIDTH, 16'(wid));
    write_reg(wb3_pkg::REG_HEIGHT, 16'(hgt));
    queue_pixels(eff_width() * eff_height(), mode);
    wait_idle();
  endtask

  initial begin
    int sent;
    int w, h;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed frames
    run_frame(0, 3, 3, 0);
    run_frame(1, 3, 2, 1);
    run_frame(10, 4, 2, 2);
    run_frame(15, 3, 3, 3);
    run_frame(5, 1, 1, 0);
    run_frame(3, 0, 0, 0);
    run_frame(7, 1, 4, 0);
    run_frame(2, 5, 1, 3);
    // tall frame: start with the largest height, then close it early
    write_reg(wb3_pkg::REG_AMOUNT, 16'd4);
    write_reg(wb3_pkg::REG_WIDTH, 16'd3);
    write_reg(wb3_pkg::REG_HEIGHT, 16'hFFFF);
    queue_pixels(9, 0);
    wait_idle();
    write_reg(wb3_pkg::REG_HEIGHT, 16'd4);
    queue_pixels(3, 0);
    wait_idle();

    // random frames, mostly small
    sent = 55;
    while (sent < 410) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      idling_on = $urandom_range(0, 3) != 0;
      run_frame($urandom_range(0, 7) == 0 ? $urandom_range(11, 15) : $urandom_range(0, 10),
                w, h, $urandom_range(0, 5) == 0 ? 3 : 0);
      sent += w * h;
    end

    wait_idle();
    if (!failed) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

[weighted_blur_3x3.f]
rtl/wb3_pkg.sv
rtl/wb3_div.sv
rtl/weighted_blur_3x3.sv
dv/weighted_blur_3x3_tb.sv
